>>> src/suffix_array_lcp_builder_core_assert.svh
// Assertion helpers used by the builder core RTL file.
`ifndef SUFFIX_ARRAY_LCP_BUILDER_CORE_ASSERT_SVH
`define SUFFIX_ARRAY_LCP_BUILDER_CORE_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define SABLD_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication.
`define SABLD_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> src/sabld_pkg.sv
`default_nettype none
package sabld_pkg;

    localparam int MAX_LEN   = 4096;
    localparam int SYM_W     = 12;
    localparam int LEN_W     = 13;
    localparam int ADDR_W    = 12;
    localparam int IDX_W     = 14;
    localparam int BKT_DEPTH = 4096;

    localparam logic [0:0] ACT_LOAD = 1'b0;
    localparam logic [0:0] ACT_READ = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_BUILT = 2'd1;
    localparam logic [1:0] ST_RANGE     = 2'd2;
    localparam logic [1:0] ST_BAD_LOAD  = 2'd3;

    typedef struct packed {
        logic              start;
        logic              ld_we;
        logic [ADDR_W-1:0] ld_addr;
        logic [SYM_W-1:0]  ld_sym;
        logic [ADDR_W-1:0] rd_addr;
    } eng_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } eng_stat_t;

    // Memory address of a 1-based index.
    function automatic logic [ADDR_W-1:0] am1(input logic [IDX_W-1:0] x);
        logic [IDX_W-1:0] d;
        d = x - IDX_W'(1);
        return d[ADDR_W-1:0];
    endfunction

endpackage
`default_nettype wire

>>> src/sabld_ram.sv
`default_nettype none
module sabld_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

>>> src/sabld_engine.sv
`default_nettype none
module sabld_engine (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire sabld_pkg::eng_ctrl_t        ctrl,
    input  wire logic [sabld_pkg::LEN_W-1:0] n,
    output sabld_pkg::eng_stat_t             stat,
    output logic [sabld_pkg::LEN_W-1:0]      sa_q,
    output logic [sabld_pkg::LEN_W-1:0]      lcp_q,
    output logic [sabld_pkg::LEN_W-1:0]      rk_q
);
    import sabld_pkg::*;

    typedef enum logic [30:0] {
        E_IDLE  = 31'h0000_0001,
        E_SKO_A = 31'h0000_0002,
        E_SKO_C = 31'h0000_0004,
        E_FET_A = 31'h0000_0008,
        E_FET_B = 31'h0000_0010,
        E_CLR   = 31'h0000_0020,
        E_CNT_A = 31'h0000_0040,
        E_CNT_B = 31'h0000_0080,
        E_CNT_C = 31'h0000_0100,
        E_PFX_A = 31'h0000_0200,
        E_PFX_B = 31'h0000_0400,
        E_PLC_A = 31'h0000_0800,
        E_PLC_B = 31'h0000_1000,
        E_PLC_C = 31'h0000_2000,
        E_RNK_A = 31'h0000_4000,
        E_RNK_B = 31'h0000_8000,
        E_RNK_C = 31'h0001_0000,
        E_RNK_D = 31'h0002_0000,
        E_RNK_E = 31'h0004_0000,
        E_CPY_A = 31'h0008_0000,
        E_CPY_B = 31'h0010_0000,
        E_RKP_A = 31'h0020_0000,
        E_RKP_B = 31'h0040_0000,
        E_KAS_A = 31'h0080_0000,
        E_KAS_B = 31'h0100_0000,
        E_KAS_C = 31'h0200_0000,
        E_KAS_D = 31'h0400_0000,
        E_KAS_E = 31'h0800_0000,
        E_KAS_F = 31'h1000_0000,
        E_KAS_W = 31'h2000_0000,
        E_FIN   = 31'h4000_0000
    } eng_state_t;

    typedef enum logic [2:0] {
        SEG_INIT = 3'b001,
        SEG_TAIL = 3'b010,
        SEG_SCAN = 3'b100
    } seg_t;

    localparam logic [ADDR_W-1:0] BKT_LAST = ADDR_W'(BKT_DEPTH - 1);

    eng_state_t state_reg, state_next;
    seg_t       seg_reg, seg_next;
    logic [IDX_W-1:0] i_reg, i_next, k_reg, k_next;
    logic [LEN_W-1:0] tot_reg, tot_next, e_reg, e_next, key_reg, key_next;
    logic [LEN_W-1:0] acc_reg, acc_next, rank_reg, rank_next;
    logic [LEN_W-1:0] p1_reg, p1_next, p2_reg, p2_next, c1_reg, c1_next, c2_reg, c2_next;
    logic [LEN_W-1:0] h_reg, h_next, r_reg, r_next, j_reg, j_next;
    logic [SYM_W-1:0] a_reg, a_next;
    logic             pass0_reg, pass0_next;

    // Memory ports.
    logic              txt_we, kq_we, sk_we, sa_we, fr_we, nr_we, bk_we, rk_we, lcp_we;
    logic [ADDR_W-1:0] txt_wa, kq_wa, sk_wa, sa_wa, fr_wa, nr_wa, bk_wa, rk_wa, lcp_wa;
    logic [ADDR_W-1:0] txt_ra, kq_ra, sk_ra, sa_ra, fr_ra, nr_ra, bk_ra, rk_ra, lcp_ra;
    logic [SYM_W-1:0]  txt_wd, txt_rd;
    logic [LEN_W-1:0]  kq_wd, sk_wd, sa_wd, fr_wd, nr_wd, bk_wd, rk_wd, lcp_wd;
    logic [LEN_W-1:0]  kq_rd, sk_rd, sa_rd, fr_rd, nr_rd, bk_rd;

    logic [IDX_W-1:0] n_x, kk, ih, jh, eh;
    logic             diff;

    assign n_x = {1'b0, n};
    assign kk  = pass0_reg ? k_reg : (k_reg << 1);
    assign ih  = i_reg + {1'b0, h_reg};
    assign jh  = {1'b0, j_reg} + {1'b0, h_reg};
    assign eh  = {1'b0, e_reg} + k_reg;
    assign diff = (c1_reg != p1_reg) || (c2_reg != p2_reg);

    always_comb
    begin
        state_next = state_reg;
        seg_next   = seg_reg;
        i_next     = i_reg;
        k_next     = k_reg;
        tot_next   = tot_reg;
        e_next     = e_reg;
        key_next   = key_reg;
        acc_next   = acc_reg;
        rank_next  = rank_reg;
        p1_next    = p1_reg;
        p2_next    = p2_reg;
        c1_next    = c1_reg;
        c2_next    = c2_reg;
        h_next     = h_reg;
        r_next     = r_reg;
        j_next     = j_reg;
        a_next     = a_reg;
        pass0_next = pass0_reg;

        txt_we = ctrl.ld_we;  txt_wa = ctrl.ld_addr;  txt_wd = ctrl.ld_sym;
        kq_we  = 1'b0;        kq_wa  = am1(IDX_W'(tot_reg));
        kq_wd  = pass0_reg ? {1'b0, txt_rd} : fr_rd;
        sk_we  = 1'b0;        sk_wa  = am1(IDX_W'(tot_reg));  sk_wd = e_reg;
        sa_we  = 1'b0;        sa_wa  = am1(IDX_W'(bk_rd));    sa_wd = e_reg;
        fr_we  = 1'b0;        fr_wa  = am1(i_reg);            fr_wd = nr_rd;
        nr_we  = 1'b0;        nr_wa  = am1(IDX_W'(e_reg));
        nr_wd  = (i_reg == IDX_W'(1)) ? LEN_W'(1) : rank_reg + LEN_W'(diff);
        bk_we  = 1'b0;        bk_wa  = am1(IDX_W'(key_reg));  bk_wd = bk_rd + LEN_W'(1);
        rk_we  = 1'b0;        rk_wa  = am1(IDX_W'(sa_rd));    rk_wd = i_reg[LEN_W-1:0];
        lcp_we = 1'b0;        lcp_wa = am1(IDX_W'(r_reg) - IDX_W'(1)); lcp_wd = h_reg;

        txt_ra = am1(IDX_W'(e_reg));
        kq_ra  = am1(i_reg);
        sk_ra  = am1(i_reg);
        sa_ra  = ctrl.rd_addr;
        fr_ra  = am1(IDX_W'(e_reg));
        nr_ra  = am1(i_reg);
        bk_ra  = am1(IDX_W'(kq_rd));
        rk_ra  = ctrl.rd_addr;
        lcp_ra = ctrl.rd_addr;

        case (state_reg)
            E_IDLE:
            begin
                if (ctrl.start)
                begin
                    pass0_next = 1'b1;
                    k_next     = IDX_W'(1);
                    seg_next   = SEG_INIT;
                    i_next     = IDX_W'(1);
                    tot_next   = LEN_W'(1);
                    state_next = E_SKO_A;
                end
            end
            E_SKO_A:
            begin
                if (i_reg > n_x)
                begin
                    if (seg_reg == SEG_TAIL)
                    begin
                        seg_next = SEG_SCAN;
                        i_next   = IDX_W'(1);
                    end
                    else
                    begin
                        i_next     = '0;
                        state_next = E_CLR;
                    end
                end
                else if (seg_reg == SEG_SCAN)
                begin
                    sa_ra      = am1(i_reg);
                    state_next = E_SKO_C;
                end
                else
                begin
                    e_next     = i_reg[LEN_W-1:0];
                    state_next = E_FET_A;
                end
            end
            E_SKO_C:
            begin
                if ({1'b0, sa_rd} > k_reg)
                begin
                    e_next     = LEN_W'({1'b0, sa_rd} - k_reg);
                    state_next = E_FET_A;
                end
                else
                begin
                    i_next     = i_reg + IDX_W'(1);
                    state_next = E_SKO_A;
                end
            end
            E_FET_A:
            begin
                state_next = E_FET_B;
            end
            E_FET_B:
            begin
                sk_we      = 1'b1;
                kq_we      = 1'b1;
                tot_next   = tot_reg + LEN_W'(1);
                i_next     = i_reg + IDX_W'(1);
                state_next = E_SKO_A;
            end
            E_CLR:
            begin
                bk_we = 1'b1;
                bk_wa = i_reg[ADDR_W-1:0];
                bk_wd = '0;
                if (i_reg[ADDR_W-1:0] == BKT_LAST)
                begin
                    i_next     = IDX_W'(1);
                    state_next = E_CNT_A;
                end
                else
                begin
                    i_next = i_reg + IDX_W'(1);
                end
            end
            E_CNT_A:
            begin
                if (i_reg > n_x)
                begin
                    i_next     = '0;
                    acc_next   = '0;
                    state_next = E_PFX_A;
                end
                else
                begin
                    state_next = E_CNT_B;
                end
            end
            E_CNT_B:
            begin
                key_next   = kq_rd;
                state_next = E_CNT_C;
            end
            E_CNT_C:
            begin
                bk_we      = 1'b1;
                i_next     = i_reg + IDX_W'(1);
                state_next = E_CNT_A;
            end
            E_PFX_A:
            begin
                bk_ra      = i_reg[ADDR_W-1:0];
                state_next = E_PFX_B;
            end
            E_PFX_B:
            begin
                bk_we    = 1'b1;
                bk_wa    = i_reg[ADDR_W-1:0];
                bk_wd    = acc_reg + bk_rd;
                acc_next = acc_reg + bk_rd;
                if (i_reg[ADDR_W-1:0] == BKT_LAST)
                begin
                    i_next     = n_x;
                    state_next = E_PLC_A;
                end
                else
                begin
                    i_next     = i_reg + IDX_W'(1);
                    state_next = E_PFX_A;
                end
            end
            E_PLC_A:
            begin
                if (i_reg == '0)
                begin
                    i_next     = IDX_W'(1);
                    state_next = E_RNK_A;
                end
                else
                begin
                    state_next = E_PLC_B;
                end
            end
            E_PLC_B:
            begin
                key_next   = kq_rd;
                e_next     = sk_rd;
                state_next = E_PLC_C;
            end
            E_PLC_C:
            begin
                // Scatter the element to its bucket slot, then step the slot back.
                sa_we      = 1'b1;
                bk_we      = 1'b1;
                bk_wd      = bk_rd - LEN_W'(1);
                i_next     = i_reg - IDX_W'(1);
                state_next = E_PLC_A;
            end
            E_RNK_A:
            begin
                if (i_reg > n_x)
                begin
                    i_next     = IDX_W'(1);
                    state_next = E_CPY_A;
                end
                else
                begin
                    sa_ra      = am1(i_reg);
                    state_next = E_RNK_B;
                end
            end
            E_RNK_B:
            begin
                e_next     = sa_rd;
                txt_ra     = am1(IDX_W'(sa_rd));
                fr_ra      = am1(IDX_W'(sa_rd));
                state_next = E_RNK_C;
            end
            E_RNK_C:
            begin
                c1_next = pass0_reg ? {1'b0, txt_rd} : fr_rd;
                if (!pass0_reg && eh <= n_x)
                begin
                    fr_ra      = am1(eh);
                    state_next = E_RNK_D;
                end
                else
                begin
                    c2_next    = '0;
                    state_next = E_RNK_E;
                end
            end
            E_RNK_D:
            begin
                c2_next    = fr_rd;
                state_next = E_RNK_E;
            end
            E_RNK_E:
            begin
                nr_we      = 1'b1;
                rank_next  = nr_wd;
                p1_next    = c1_reg;
                p2_next    = c2_reg;
                i_next     = i_reg + IDX_W'(1);
                state_next = E_RNK_A;
            end
            E_CPY_A:
            begin
                if (i_reg > n_x)
                begin
                    if ({1'b0, rank_reg} < n_x && kk < n_x)
                    begin
                        k_next     = kk;
                        pass0_next = 1'b0;
                        seg_next   = SEG_TAIL;
                        i_next     = n_x - kk + IDX_W'(1);
                        tot_next   = LEN_W'(1);
                        state_next = E_SKO_A;
                    end
                    else
                    begin
                        i_next     = IDX_W'(1);
                        state_next = E_RKP_A;
                    end
                end
                else
                begin
                    state_next = E_CPY_B;
                end
            end
            E_CPY_B:
            begin
                fr_we      = 1'b1;
                i_next     = i_reg + IDX_W'(1);
                state_next = E_CPY_A;
            end
            E_RKP_A:
            begin
                if (i_reg > n_x)
                begin
                    i_next     = IDX_W'(1);
                    h_next     = '0;
                    state_next = E_KAS_A;
                end
                else
                begin
                    sa_ra      = am1(i_reg);
                    state_next = E_RKP_B;
                end
            end
            E_RKP_B:
            begin
                rk_we      = 1'b1;
                i_next     = i_reg + IDX_W'(1);
                state_next = E_RKP_A;
            end
            E_KAS_A:
            begin
                if (i_reg > n_x)
                begin
                    state_next = E_FIN;
                end
                else
                begin
                    rk_ra      = am1(i_reg);
                    state_next = E_KAS_B;
                end
            end
            E_KAS_B:
            begin
                r_next = rk_q;
                if (rk_q > LEN_W'(1))
                begin
                    sa_ra      = am1(IDX_W'(rk_q) - IDX_W'(1));
                    state_next = E_KAS_C;
                end
                else
                begin
                    h_next     = '0;
                    i_next     = i_reg + IDX_W'(1);
                    state_next = E_KAS_A;
                end
            end
            E_KAS_C:
            begin
                j_next = sa_rd;
                if (h_reg != '0)
                begin
                    h_next = h_reg - LEN_W'(1);
                end
                state_next = E_KAS_D;
            end
            E_KAS_D:
            begin
                if (ih <= n_x && jh <= n_x)
                begin
                    txt_ra     = am1(ih);
                    state_next = E_KAS_E;
                end
                else
                begin
                    state_next = E_KAS_W;
                end
            end
            E_KAS_E:
            begin
                a_next     = txt_rd;
                txt_ra     = am1(jh);
                state_next = E_KAS_F;
            end
            E_KAS_F:
            begin
                if (txt_rd == a_reg)
                begin
                    h_next     = h_reg + LEN_W'(1);
                    state_next = E_KAS_D;
                end
                else
                begin
                    state_next = E_KAS_W;
                end
            end
            E_KAS_W:
            begin
                lcp_we     = 1'b1;
                i_next     = i_reg + IDX_W'(1);
                state_next = E_KAS_A;
            end
            E_FIN:
            begin
                lcp_we     = 1'b1;
                lcp_wa     = am1(n_x);
                lcp_wd     = '0;
                state_next = E_IDLE;
            end
            default:
            begin
                state_next = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= E_IDLE;
            seg_reg   <= SEG_INIT;
            pass0_reg <= 1'b1;
            i_reg     <= '0;
            k_reg     <= '0;
            tot_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            seg_reg   <= seg_next;
            pass0_reg <= pass0_next;
            i_reg     <= i_next;
            k_reg     <= k_next;
            tot_reg   <= tot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        e_reg    <= e_next;
        key_reg  <= key_next;
        acc_reg  <= acc_next;
        rank_reg <= rank_next;
        p1_reg   <= p1_next;
        p2_reg   <= p2_next;
        c1_reg   <= c1_next;
        c2_reg   <= c2_next;
        h_reg    <= h_next;
        r_reg    <= r_next;
        j_reg    <= j_next;
        a_reg    <= a_next;
    end

    assign stat.busy = (state_reg != E_IDLE);
    assign stat.done = (state_reg == E_FIN);
    assign sa_q      = sa_rd;

    sabld_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN)) u_txt (.clk(clk), .we(txt_we),
        .waddr(txt_wa), .wdata(txt_wd), .raddr(txt_ra), .rdata(txt_rd));
    sabld_ram #(.WIDTH(LEN_W), .DEPTH(MAX_LEN)) u_kq (.clk(clk), .we(kq_we),
        .waddr(kq_wa), .wdata(kq_wd), .raddr(kq_ra), .rdata(kq_rd));
    sabld_ram #(.WIDTH(LEN_W), .DEPTH(MAX_LEN)) u_sk (.clk(clk), .we(sk_we),
        .waddr(sk_wa), .wdata(sk_wd), .raddr(sk_ra), .rdata(sk_rd));
    sabld_ram #(.WIDTH(LEN_W), .DEPTH(MAX_LEN)) u_sa (.clk(clk), .we(sa_we),
        .waddr(sa_wa), .wdata(sa_wd), .raddr(sa_ra), .rdata(sa_rd));
    sabld_ram #(.WIDTH(LEN_W), .DEPTH(MAX_LEN)) u_fr (.clk(clk), .we(fr_we),
        .waddr(fr_wa), .wdata(fr_wd), .raddr(fr_ra), .rdata(fr_rd));
    sabld_ram #(.WIDTH(LEN_W), .DEPTH(MAX_LEN)) u_nr (.clk(clk), .we(nr_we),
        .waddr(nr_wa), .wdata(nr_wd), .raddr(nr_ra), .rdata(nr_rd));
    sabld_ram #(.WIDTH(LEN_W), .DEPTH(BKT_DEPTH)) u_bk (.clk(clk), .we(bk_we),
        .waddr(bk_wa), .wdata(bk_wd), .raddr(bk_ra), .rdata(bk_rd));
    sabld_ram #(.WIDTH(LEN_W), .DEPTH(MAX_LEN)) u_rk (.clk(clk), .we(rk_we),
        .waddr(rk_wa), .wdata(rk_wd), .raddr(rk_ra), .rdata(rk_q));
    sabld_ram #(.WIDTH(LEN_W), .DEPTH(MAX_LEN)) u_lcp (.clk(clk), .we(lcp_we),
        .waddr(lcp_wa), .wdata(lcp_wd), .raddr(lcp_ra), .rdata(lcp_q));

endmodule
`default_nettype wire

>>> src/suffix_array_lcp_builder_core.sv
`default_nettype none
// Suffix array and LCP builder. Symbols are streamed in one item each; the item with tlast
// set starts a build of a non-empty text that sorts all suffixes by prefix doubling with
// counting-sort passes and then derives neighbor LCP values by Kasai's method. A load writes
// its symbol straight into the text memory. A read passes through the T_READ state, where its
// result is registered, and s_tready is low in that state. During a build s_tready stays low:
// the build is run by a single sequencer over memories with one read and one write port. Each
// sort pass clears the 4096 buckets, counts the keys, prefix-sums the buckets and places the
// suffixes; there are at most log2 of the text length, rounded up, plus one passes. The LCP
// stage then compares characters of neighboring suffixes.
// Results carry status 0 ok, 1 not built, 2 index out of range, 3 bad symbol or full text.
module suffix_array_lcp_builder_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [11:0] cfg_wdata,   // symbol_limit
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,     // [11:0] symbol, [24:12] query_index, rest zero
    input  wire logic        s_tlast,     // last_symbol
    input  wire logic        s_tuser,     // action: 0 load, 1 read
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata      // [12:0] suffix_start, [25:13] common_prefix,
                                          // [38:26] position_rank, [51:39] text_count,
                                          // [53:52] status, rest zero
);
    import sabld_pkg::*;

    `include "suffix_array_lcp_builder_core_assert.svh"

    typedef enum logic [2:0] {
        T_IDLE  = 3'b001,
        T_READ  = 3'b010,
        T_BUILD = 3'b100
    } top_state_t;

    top_state_t       state_reg, state_next;
    logic [11:0]      limit_reg;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             built_reg, built_next;
    logic             mv_reg, mv_next;
    logic [55:0]      md_reg, md_next;

    eng_ctrl_t        ctrl;
    eng_stat_t        stat;
    logic [LEN_W-1:0] sa_q, lcp_q, rk_q;

    logic [SYM_W-1:0] sym;
    logic [LEN_W-1:0] q, len_eff, new_len;
    logic             acc, bad, q_bad;

    assign sym      = s_tdata[11:0];
    assign q        = s_tdata[24:12];
    assign s_tready = (state_reg == T_IDLE) && (!mv_reg || m_tready);
    assign acc      = s_tvalid && s_tready;
    assign len_eff  = built_reg ? '0 : len_reg;
    assign bad      = (sym == '0) || (sym > limit_reg) || (len_eff >= LEN_W'(MAX_LEN));
    assign new_len  = bad ? len_eff : len_eff + LEN_W'(1);
    assign q_bad    = (q == '0) || (q > len_reg);

    function automatic logic [55:0] pack(input logic [LEN_W-1:0] s, input logic [LEN_W-1:0] l,
                                         input logic [LEN_W-1:0] r, input logic [LEN_W-1:0] c,
                                         input logic [1:0] st);
        return {2'b00, st, c, r, l, s};
    endfunction

    always_comb
    begin
        state_next   = state_reg;
        len_next     = len_reg;
        built_next   = built_reg;
        mv_next      = mv_reg && !m_tready;
        md_next      = md_reg;
        ctrl.start   = 1'b0;
        ctrl.ld_we   = 1'b0;
        ctrl.ld_addr = len_eff[ADDR_W-1:0];
        ctrl.ld_sym  = sym;
        ctrl.rd_addr = am1(IDX_W'(q));

        case (state_reg)
            T_IDLE:
            begin
                if (acc)
                begin
                    if (s_tuser == ACT_LOAD)
                    begin
                        // A load after a finished build starts a new text.
                        built_next = 1'b0;
                        len_next   = new_len;
                        ctrl.ld_we = !bad;
                        if (s_tlast)
                        begin
                            mv_next = 1'b1;
                            md_next = pack('0, '0, '0, new_len,
                                           bad ? ST_BAD_LOAD :
                                           (new_len == '0) ? ST_NOT_BUILT : ST_OK);
                            if (new_len != '0)
                            begin
                                ctrl.start = 1'b1;
                                state_next = T_BUILD;
                            end
                        end
                        else if (bad)
                        begin
                            mv_next = 1'b1;
                            md_next = pack('0, '0, '0, new_len, ST_BAD_LOAD);
                        end
                    end
                    else if (!built_reg)
                    begin
                        mv_next = 1'b1;
                        md_next = pack('0, '0, '0, len_reg, ST_NOT_BUILT);
                    end
                    else if (q_bad)
                    begin
                        mv_next = 1'b1;
                        md_next = pack('0, '0, '0, len_reg, ST_RANGE);
                    end
                    else
                    begin
                        state_next = T_READ;
                    end
                end
            end
            T_READ:
            begin
                // The result register was free when the read was taken.
                mv_next    = 1'b1;
                md_next    = pack(sa_q, lcp_q, rk_q, len_reg, ST_OK);
                state_next = T_IDLE;
            end
            T_BUILD:
            begin
                if (stat.done)
                begin
                    built_next = 1'b1;
                    state_next = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_IDLE;
            limit_reg <= 12'd255;
            len_reg   <= '0;
            built_reg <= 1'b0;
            mv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            len_reg   <= len_next;
            built_reg <= built_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        md_reg <= md_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;

    sabld_engine u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .n     (len_reg),
        .stat  (stat),
        .sa_q  (sa_q),
        .lcp_q (lcp_q),
        .rk_q  (rk_q)
    );

    `SABLD_IMPLY(a_no_accept_in_build, stat.busy, !s_tready)
    `SABLD_NEXT(a_done_single, stat.done, !stat.done)
    `SABLD_NEXT(a_built_after_done, stat.done, built_reg && state_reg == T_IDLE)

endmodule
`default_nettype wire
